>>> rtl/alu64_pkg.sv
// Package for the signed 64-bit ALU: transaction structs, operation and status codes,
// and the pipeline stage record. No dependencies.
`timescale 1ns / 1ps
package alu64_pkg;

   // Operation codes carried in req_type.
   localparam logic [3:0] OP_ADD   = 4'd0;
   localparam logic [3:0] OP_SUB   = 4'd1;
   localparam logic [3:0] OP_MUL   = 4'd2;
   localparam logic [3:0] OP_FDIV  = 4'd3;
   localparam logic [3:0] OP_FMOD  = 4'd4;
   localparam logic [3:0] OP_TQUOT = 4'd5;
   localparam logic [3:0] OP_TREM  = 4'd6;
   localparam logic [3:0] OP_EQ    = 4'd7;
   localparam logic [3:0] OP_LT    = 4'd8;
   localparam logic [3:0] OP_LE    = 4'd9;

   // Status codes.
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DIV0 = 2'd1;
   localparam logic [1:0] ST_OVF  = 2'd2;

   // Divider geometry: quotient bits resolved per stage and number of stages.
   localparam int DIV_BITS   = 2;
   localparam int DIV_STAGES = 64 / DIV_BITS;

   localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic [3:0]         req_type;
      logic signed [63:0] operand_x;
      logic signed [63:0] operand_y;
   } alu_req_type;

   typedef struct packed {
      logic signed [63:0] result_value;
      logic [1:0]         status;
   } alu_rsp_type;

   // State of one transaction as it travels down the pipeline.
   typedef struct packed {
      logic [3:0]   op;
      logic [63:0]  x;
      logic [63:0]  y;
      logic         neg_q;
      logic         neg_x;
      logic [63:0]  ay;
      logic [63:0]  rem;
      logic [63:0]  quo;
      logic [63:0]  pp00;
      logic [63:0]  pp01;
      logic [63:0]  pp10;
      logic [63:0]  pp11;
      logic [127:0] prod;
      logic         done;
      logic [63:0]  res;
      logic [1:0]   st;
   } alu_stage_type;

endpackage

>>> rtl/signed_int64_alu_with_floor_division.sv
// Top level of the signed 64-bit ALU with floor and truncated division.
// Depends on alu64_pkg for the transaction structs, codes and stage record.
`timescale 1ns / 1ps
// A fully pipelined ALU that accepts one transaction every cycle while req_stall is
// low and returns one result per transaction, in order. The divider resolves two
// quotient bits in each of 32 stages, between one operand preparation stage and one
// sign fixup stage; the other operations ride along the same pipeline. The whole
// pipeline advances together: when the output register holds a result that the
// receiver stalls, req_stall is raised in the same cycle and nothing moves.
module signed_int64_alu_with_floor_division (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  alu64_pkg::alu_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output alu64_pkg::alu_rsp_type rsp_data
);
   import alu64_pkg::*;

   // Stage 0 captures the request, stage 1 holds the prepared operands, stages
   // 2..DIV_STAGES+1 divide, and the last holds the result.
   localparam int LAST = DIV_STAGES + 2;

   alu_stage_type stg_ff [0:LAST];
   alu_stage_type stg_in [0:LAST];
   logic [LAST:0] vld_ff;
   logic [LAST:0] vld_in;
   logic          adv;

   // The pipeline moves unless the finished result is being held back.
   assign adv       = !(vld_ff[LAST] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[LAST];
   assign rsp_data.result_value = stg_ff[LAST].res;
   assign rsp_data.status       = stg_ff[LAST].st;

   // Next state of every stage.
   always_comb begin
      alu_stage_type s;
      alu_stage_type n;
      logic [63:0]   sum;
      logic [63:0]   dif;
      logic [63:0]   lo;
      logic [63:0]   neg_lo;
      logic          mul_ovf;
      logic [63:0]   r;
      logic [63:0]   q;
      logic [63:0]   t;
      logic [63:0]   srem;
      logic          adjust;

      vld_in[0]         = req_valid;
      stg_in[0]         = '0;
      stg_in[0].op      = req_data.req_type;
      stg_in[0].x       = req_data.operand_x;
      stg_in[0].y       = req_data.operand_y;
      for (int k = 0; k < LAST; k++) begin
         s = stg_ff[k];
         n = s;
         sum     = '0;
         dif     = '0;
         lo      = '0;
         neg_lo  = '0;
         mul_ovf = 1'b0;
         r       = '0;
         q       = '0;
         t       = '0;
         srem    = '0;
         adjust  = 1'b0;
         vld_in[k + 1] = vld_ff[k];
         if (k == 0) begin
            // Operand preparation, and the operations that complete in this stage.
            n.neg_x = s.x[63];
            n.neg_q = s.x[63] ^ s.y[63];
            n.quo   = s.x[63] ? (64'd0 - s.x) : s.x;
            n.ay    = s.y[63] ? (64'd0 - s.y) : s.y;
            n.rem   = '0;
            sum = s.x + s.y;
            dif = s.x - s.y;
            n.done = 1'b1;
            n.res  = '0;
            n.st   = ST_OK;
            case (s.op)
               OP_ADD: begin
                  if (((s.x ^ sum) & (s.y ^ sum) & SIGN_BIT) != '0) n.st = ST_OVF;
                  else n.res = sum;
               end
               OP_SUB: begin
                  if (((s.x ^ s.y) & (s.x ^ dif) & SIGN_BIT) != '0) n.st = ST_OVF;
                  else n.res = dif;
               end
               OP_MUL: n.done = 1'b0;
               OP_FDIV, OP_FMOD, OP_TQUOT, OP_TREM: begin
                  if (s.y == '0) begin
                     n.st = ST_DIV0;
                  end else if (s.x == SIGN_BIT && s.y == '1) begin
                     // Most negative dividend over minus one.
                     if (s.op == OP_FDIV || s.op == OP_TQUOT) n.st = ST_OVF;
                  end else begin
                     n.done = 1'b0;
                  end
               end
               OP_EQ: n.res = {63'd0, s.x == s.y};
               OP_LT: n.res = {63'd0, $signed(s.x) < $signed(s.y)};
               OP_LE: n.res = {63'd0, !($signed(s.y) < $signed(s.x))};
               default: n.res = '0;
            endcase
         end else if (k <= DIV_STAGES) begin
            // Restoring division, DIV_BITS quotient bits per stage.
            r = s.rem;
            q = s.quo;
            for (int b = 0; b < DIV_BITS; b++) begin
               r = {r[62:0], q[63]};
               q = {q[62:0], 1'b0};
               if (r >= s.ay) begin
                  r    = r - s.ay;
                  q[0] = 1'b1;
               end
            end
            n.rem = r;
            n.quo = q;
            // Multiplier: partial products, then their sum, then range check.
            if (k == 1) begin
               n.pp00 = {32'd0, s.quo[31:0]}  * {32'd0, s.ay[31:0]};
               n.pp01 = {32'd0, s.quo[31:0]}  * {32'd0, s.ay[63:32]};
               n.pp10 = {32'd0, s.quo[63:32]} * {32'd0, s.ay[31:0]};
               n.pp11 = {32'd0, s.quo[63:32]} * {32'd0, s.ay[63:32]};
            end else if (k == 2) begin
               n.prod = {64'd0, s.pp00} + {32'd0, s.pp01, 32'd0}
                      + {32'd0, s.pp10, 32'd0} + {s.pp11, 64'd0};
            end else if (k == 3) begin
               lo      = s.prod[63:0];
               neg_lo  = 64'd0 - lo;
               mul_ovf = (s.prod[127:64] != '0) || (s.neg_q ? (lo > SIGN_BIT)
                                                           : (lo >= SIGN_BIT));
               if (s.op == OP_MUL) begin
                  n.done = 1'b1;
                  if (mul_ovf) begin
                     n.st  = ST_OVF;
                     n.res = '0;
                  end else begin
                     n.res = s.neg_q ? neg_lo : lo;
                  end
               end
            end
         end else begin
            // Sign fixup for the four division operations.
            if (!s.done) begin
               adjust = s.neg_q && (s.rem != '0);
               q      = s.neg_q ? (64'd0 - s.quo) : s.quo;
               srem   = s.neg_x ? (64'd0 - s.rem) : s.rem;
               t      = s.neg_x ? (s.y - s.rem) : (s.y + s.rem);
               case (s.op)
                  OP_TQUOT: n.res = q;
                  OP_TREM:  n.res = srem;
                  OP_FDIV:  n.res = adjust ? ~s.quo : q;
                  OP_FMOD:  n.res = adjust ? t : srem;
                  default:  n.res = '0;
               endcase
               n.done = 1'b1;
            end
         end
         stg_in[k + 1] = n;
      end
   end

   // Valid bits of every stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Stage payload registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= LAST; k++) stg_ff[k] <= stg_in[k];
      end
   end

endmodule
